[rtl/cfrp_pkg.sv]
// Shared types and constants for the framed reply parser.
package cfrp_pkg;

  localparam int unsigned FRAME_BYTES = 13;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0]  START_MARK = 8'h02;
  localparam logic [7:0]  END_MARK   = 8'h03;
  localparam logic [15:0] CRC_TOP    = 16'h8000;
  localparam logic [15:0] POLY_RESET = 16'h8001;
  localparam logic [15:0] SEED_RESET = 16'h0000;

  // byte positions inside the reply frame
  localparam logic [POS_W-1:0] POS_JOINT     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MOTOR_HI  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_MOTOR_LO  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_GEAR_HI   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_GEAR_LO   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_SWITCHES  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_READY     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_CRC_LAST  = POS_W'(9);
  localparam logic [POS_W-1:0] POS_CRC_HI    = POS_W'(10);
  localparam logic [POS_W-1:0] POS_CRC_LO    = POS_W'(11);

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_CRC_POLY = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_CRC_SEED = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_MARKER = 2'd1,
    ST_CRC    = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t      frame_status;
    logic [7:0]         joint_num;
    logic signed [15:0] motor_pos;
    logic signed [15:0] gear_pos;
    logic               limit_one;
    logic               limit_two;
    logic [7:0]         ready_status;
    logic [15:0]        crc_computed;
    logic [15:0]        crc_in_frame;
  } result_t;

  localparam int unsigned OUT_DATA_W = 88;

endpackage

[rtl/cfrp_crc8.sv]
// Byte-wide MSB-first CRC-16 update, eight shift steps unrolled.
module cfrp_crc8 import cfrp_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [15:0] poly,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[rtl/cfrp_frame.sv]
// Frame tracker: byte position, running CRC, field capture and result build.
module cfrp_frame import cfrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic [15:0] crc_poly,
  input  logic [15:0] crc_seed,
  output logic        at_last,
  output logic        res_valid,
  output result_t     res
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_eff;
  logic [15:0]      crc_running;
  logic [15:0]      crc_base;
  logic [15:0]      crc_next;
  logic             start_ok;
  logic [7:0]       cap_joint;
  logic [15:0]      cap_motor;
  logic [15:0]      cap_gear;
  logic [7:0]       cap_switches;
  logic [7:0]       cap_ready;
  logic [15:0]      cap_crc;

  // a new frame start, or an out-of-range position, restarts at byte 0
  assign pos_eff  = (frame_start || pos > LAST_POS) ? '0 : pos;
  assign at_last  = (pos == LAST_POS);
  assign crc_base = (pos_eff == '0) ? crc_seed : crc_running;

  cfrp_crc8 u_crc (
    .crc_in  (crc_base),
    .poly    (crc_poly),
    .data    (rx_byte),
    .crc_out (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      crc_running <= '0;
      start_ok    <= 1'b0;
    end else if (accept) begin
      pos <= (pos_eff == LAST_POS) ? '0 : pos_eff + POS_W'(1);
      if (pos_eff <= POS_CRC_LAST) begin
        crc_running <= crc_next;
      end
      if (pos_eff == '0) begin
        start_ok <= (rx_byte == START_MARK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (pos_eff)
        POS_JOINT:    cap_joint        <= rx_byte;
        POS_MOTOR_HI: cap_motor[15:8]  <= rx_byte;
        POS_MOTOR_LO: cap_motor[7:0]   <= rx_byte;
        POS_GEAR_HI:  cap_gear[15:8]   <= rx_byte;
        POS_GEAR_LO:  cap_gear[7:0]    <= rx_byte;
        POS_SWITCHES: cap_switches     <= rx_byte;
        POS_READY:    cap_ready        <= rx_byte;
        POS_CRC_HI:   cap_crc[15:8]    <= rx_byte;
        POS_CRC_LO:   cap_crc[7:0]     <= rx_byte;
        default: ;
      endcase
    end
  end

  // result is formed from the end byte and the captured frame
  assign res_valid = accept && (pos_eff == LAST_POS);

  always_comb begin
    if (!start_ok || rx_byte != END_MARK) begin
      res.frame_status = ST_MARKER;
    end else if (crc_running != cap_crc) begin
      res.frame_status = ST_CRC;
    end else begin
      res.frame_status = ST_VALID;
    end
    res.joint_num    = cap_joint;
    res.motor_pos    = cap_motor;
    res.gear_pos     = cap_gear;
    res.limit_one    = cap_switches[0];
    res.limit_two    = cap_switches[1];
    res.ready_status = cap_ready;
    res.crc_computed = crc_running;
    res.crc_in_frame = cap_crc;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_POS)
    else $error("byte position left the frame");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> pos == POS_W'(1))
    else $error("frame start did not restart the frame");

  a_result_wraps: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> pos == '0)
    else $error("position did not wrap after the end byte");
`endif

endmodule

[rtl/cfrp_out_reg.sv]
// Output register for one parsed result; holds it until the sink takes it.
module cfrp_out_reg import cfrp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    take,
  output logic    valid,
  output result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

[rtl/crc_framed_reply_parser.sv]
// Top level of the framed reply parser with CRC-16 check.
//
//  channel  direction  tdata                  tuser
//  s_*      in         rx_byte                frame_start
//  m_*      out        parsed frame fields    frame_status
//  cfg_*    in         crc_poly / crc_seed write, no handshake
//
//  One byte per cycle while s_tready is high; the CRC byte update and field
//  capture are combinational, into the frame and output registers.
//  A result appears in the output register the cycle after byte 12.
//  Input stalls only when byte 12 is next and the output register still
//  holds an untaken result; other bytes flow while the result waits.
//  rst is synchronous, active high; it restores poly 0x8001, seed 0 and
//  returns to byte 0 with no result pending.
module crc_framed_reply_parser import cfrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  input  logic                  s_tuser,   // [0] frame_start
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] joint_num, [23:8] motor_pos,
                                           // [39:24] gear_pos, [40] limit_one,
                                           // [41] limit_two, [49:42] ready_status,
                                           // [65:50] crc_computed,
                                           // [81:66] crc_in_frame, [87:82] zero
  output logic [1:0]            m_tuser,   // [1:0] frame_status
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]           cfg_wdata
);

  logic [15:0] crc_poly;
  logic [15:0] crc_seed;
  logic    in_fire;
  logic    at_last;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly <= POLY_RESET;
      crc_seed <= SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CRC_POLY: crc_poly <= cfg_wdata;
        REG_CRC_SEED: crc_seed <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a byte that may close a frame waits for room in the output register
  assign s_tready = !(at_last && m_tvalid && !m_tready);
  assign in_fire  = s_tvalid && s_tready;

  cfrp_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_fire),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser),
    .crc_poly    (crc_poly),
    .crc_seed    (crc_seed),
    .at_last     (at_last),
    .res_valid   (res_valid),
    .res         (res)
  );

  cfrp_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_valid),
    .res   (res),
    .take  (m_tready),
    .valid (m_tvalid),
    .data  (out_data)
  );

  assign m_tuser = out_data.frame_status;
  assign m_tdata = {6'b0,
                    out_data.crc_in_frame,
                    out_data.crc_computed,
                    out_data.ready_status,
                    out_data.limit_two,
                    out_data.limit_one,
                    out_data.gear_pos,
                    out_data.motor_pos,
                    out_data.joint_num};

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !m_tvalid || m_tready)
    else $error("result transaction overwrote a pending result");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result transaction changed while stalled");
`endif

endmodule

[test/tb_crc_framed_reply_parser.sv]
`timescale 1ns / 1ps
// Self-checking testbench for crc_framed_reply_parser: random frames vs. a predictor.
module tb_crc_framed_reply_parser;
  import cfrp_pkg::*;

  // Generous cap: ~1650 bytes with random sender gaps plus receiver stalls
  // lands well below this.
  localparam int CYCLE_LIMIT   = 200000;
  // result register holds the frame the cycle after byte 12; settle before each phase
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    FR_GOOD,
    FR_BAD_START,
    FR_BAD_END,
    FR_BAD_CRC
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] rx_byte
  logic                  s_tuser   = 1'b0; // [0] frame_start
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // [7:0] joint_num ... [81:66] crc_in_frame
  logic [1:0]            m_tuser;          // [1:0] frame_status
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [15:0]           cfg_wdata = '0;

  crc_framed_reply_parser dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  rx_item_t    pending_q[$];   // bytes waiting for the driver
  result_t     expected_q[$];  // parsed frames not yet seen on m_*

  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned gen_pos        = 0;  // frame position as the stimulus side sees it
  int          max_gap        = 0;  // sender idle ceiling for the current phase
  int          max_stall      = 0;  // receiver stall ceiling for the current phase
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          ready_left     = 0;
  int          stall_left     = 0;
  int          cycles         = 0;
  int          mismatches     = 0;
  int          frames_checked = 0;
  int          frames_dropped = 0;
  int          n_valid        = 0;
  int          n_marker       = 0;
  int          n_crc          = 0;
  int          settings_run   = 0;

  // Parser mirror: registers, updated on writes, and frame state, updated on every accepted byte
  logic [15:0] poly_q     = POLY_RESET;
  logic [15:0] seed_q     = SEED_RESET;
  int unsigned pos_q      = 0;
  logic [15:0] crc_q      = '0;
  logic        start_ok_q = 1'b0;
  logic [7:0]  joint_q    = '0;
  logic [15:0] motor_q    = '0;
  logic [15:0] gear_q     = '0;
  logic [7:0]  switch_q   = '0;
  logic [7:0]  ready_q    = '0;
  logic [15:0] frame_crc_q = '0;

  // MSB-first CRC-16 byte update, no reflection, no final xor
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b,
                                             logic [15:0] poly);
    logic [15:0] c;
    int          k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++)
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  // Advance the parser mirror by one accepted byte; queue a result on byte 12.
  task automatic parse_byte(logic [7:0] b, logic start);
    int unsigned p;
    result_t     r;
    // a frame start on a nonzero position throws the partial frame away
    if (start && pos_q != 0)
      frames_dropped++;
    p = (start || pos_q >= FRAME_BYTES) ? 0 : pos_q;

    if (p == 0) begin
      start_ok_q = (b == START_MARK);
      crc_q      = crc16_byte(seed_q, b, poly_q);  // seed only takes effect here
    end else if (p <= POS_CRC_LAST) begin
      crc_q = crc16_byte(crc_q, b, poly_q);
    end

    case (p)
      POS_JOINT:    joint_q = b;
      POS_MOTOR_HI: motor_q[15:8] = b;
      POS_MOTOR_LO: motor_q[7:0] = b;
      POS_GEAR_HI:  gear_q[15:8] = b;
      POS_GEAR_LO:  gear_q[7:0] = b;
      POS_SWITCHES: switch_q = b;
      POS_READY:    ready_q = b;
      POS_CRC_HI:   frame_crc_q[15:8] = b;
      POS_CRC_LO:   frame_crc_q[7:0] = b;
      default: ;
    endcase

    if (p == LAST_POS) begin
      pos_q = 0;
      // marker fault wins over a CRC fault; fields are reported either way
      if (!start_ok_q || b != END_MARK)
        r.frame_status = ST_MARKER;
      else if (crc_q != frame_crc_q)
        r.frame_status = ST_CRC;
      else
        r.frame_status = ST_VALID;
      r.joint_num    = joint_q;
      r.motor_pos    = motor_q;
      r.gear_pos     = gear_q;
      r.limit_one    = switch_q[0];
      r.limit_two    = switch_q[1];
      r.ready_status = ready_q;
      r.crc_computed = crc_q;
      r.crc_in_frame = frame_crc_q;
      expected_q.push_back(r);
    end else begin
      pos_q = p + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] b, logic start);
    rx_item_t it;
    int unsigned p;
    it.data  = b;
    it.start = start;
    pending_q.push_back(it);
    bytes_queued++;
    p       = start ? 0 : gen_pos;
    gen_pos = (p + 1 == FRAME_BYTES) ? 0 : p + 1;
  endtask

  // Angles lean toward the signed extremes and zero crossings.
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Build one reply frame under the given poly/seed and queue its first nbytes.
  // The first byte carries frame_start when forced or when alignment needs
  // it, else at random (back-to-back frames rely on the position wrap).
  task automatic queue_frame(frame_kind_t kind, logic [7:0] joint, logic [7:0] cmd,
                             logic [15:0] motor, logic [15:0] gear, logic [7:0] sw,
                             logic [7:0] rdy, logic [7:0] spare, int unsigned nbytes,
                             bit force_start, logic [15:0] poly, logic [15:0] seed);
    logic [7:0]  fr [FRAME_BYTES];
    logic [15:0] c;
    logic [7:0]  m;
    logic        first_start;
    int unsigned i;
    fr[0]            = START_MARK;
    fr[POS_JOINT]    = joint;
    fr[2]            = cmd;
    fr[POS_MOTOR_HI] = motor[15:8];
    fr[POS_MOTOR_LO] = motor[7:0];
    fr[POS_GEAR_HI]  = gear[15:8];
    fr[POS_GEAR_LO]  = gear[7:0];
    fr[POS_SWITCHES] = sw;
    fr[POS_READY]    = rdy;
    fr[POS_CRC_LAST] = spare;
    fr[LAST_POS]     = END_MARK;
    if (kind == FR_BAD_START) begin
      m = 8'($urandom);
      fr[0] = (m == START_MARK) ? ~m : m;
    end
    if (kind == FR_BAD_END) begin
      m = 8'($urandom);
      fr[LAST_POS] = (m == END_MARK) ? ~m : m;
    end
    c = seed;
    for (i = 0; i <= POS_CRC_LAST; i++)
      c = crc16_byte(c, fr[i], poly);
    if (kind == FR_BAD_CRC)
      c ^= 16'($urandom_range(1, 65535));
    fr[POS_CRC_HI] = c[15:8];
    fr[POS_CRC_LO] = c[7:0];

    first_start = (force_start || gen_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
    for (i = 0; i < nbytes; i++)
      queue_byte(fr[i], (i == 0) ? first_start : 1'b0);
  endtask

  task automatic queue_random_frame(int unsigned nbytes, logic [15:0] poly,
                                    logic [15:0] seed);
    int          r;
    frame_kind_t kind;
    r = $urandom_range(0, 99);
    if (r < 70)      kind = FR_GOOD;
    else if (r < 80) kind = FR_BAD_START;
    else if (r < 90) kind = FR_BAD_END;
    else             kind = FR_BAD_CRC;
    queue_frame(kind, 8'($urandom), 8'($urandom), pick_angle(), pick_angle(),
                8'($urandom), 8'($urandom), 8'($urandom), nbytes, 1'b0, poly, seed);
  endtask

  // All queued bytes taken and every parsed frame seen on the output.
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || expected_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One phase: sender holds off until the block has drained (every expected
  // result back), registers change while idle, then a random mix is queued.
  task automatic run_phase(bit write_regs, logic [15:0] poly, logic [15:0] seed,
                           int gap, int stall, int unsigned n_items);
    int unsigned first;
    int          r;
    int          k;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (write_regs) begin
      write_reg(REG_CRC_POLY, poly);
      write_reg(REG_CRC_SEED, seed);
    end
    max_gap   = gap;
    max_stall = stall;
    settings_run++;
    first = bytes_queued;
    while (bytes_queued - first < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        queue_random_frame(FRAME_BYTES, poly, seed);
      end else if (r < 86) begin
        // truncated frame; the next frame start drops it
        queue_random_frame($urandom_range(1, FRAME_BYTES - 1), poly, seed);
      end else begin
        // line noise with stray frame starts
        for (k = $urandom_range(1, 6); k > 0; k--)
          queue_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts from pending_q with random gaps; predicts on each transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tuser);
        bytes_accepted++;
      end
      // registers change after any byte of this edge, as in the block
      if (cfg_we) begin
        if (cfg_addr == REG_CRC_POLY)
          poly_q = cfg_wdata;
        else if (cfg_addr == REG_CRC_SEED)
          seed_q = cfg_wdata;
      end
      // only move on once the current byte is gone (or nothing is offered)
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          it = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= it.data;
          s_tuser  <= it.start;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready runs alternating with stalls, stall ceiling per phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left--;
      m_tready <= 1'b1;
    end else begin
      ready_left = $urandom_range(1, 8);
      stall_left = (max_stall > 0) ? $urandom_range(0, max_stall) : 0;
      m_tready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: unpack each result transaction and check against the oldest frame
  // ---------------------------------------------------------------------------
  function automatic string show(result_t r);
    return $sformatf("st=%0d id=%02h mot=%04h gb=%04h lim=%b%b rdy=%02h crc=%04h/%04h",
                     r.frame_status, r.joint_num, r.motor_pos, r.gear_pos,
                     r.limit_two, r.limit_one, r.ready_status, r.crc_computed,
                     r.crc_in_frame);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.frame_status = frame_status_t'(m_tuser);
      got.joint_num    = m_tdata[7:0];
      got.motor_pos    = m_tdata[23:8];
      got.gear_pos     = m_tdata[39:24];
      got.limit_one    = m_tdata[40];
      got.limit_two    = m_tdata[41];
      got.ready_status = m_tdata[49:42];
      got.crc_computed = m_tdata[65:50];
      got.crc_in_frame = m_tdata[81:66];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0d] result with no frame pending: %s", cycles, show(got));
      end else begin
        want = expected_q.pop_front();
        frames_checked++;
        case (want.frame_status)
          ST_VALID:  n_valid++;
          ST_MARKER: n_marker++;
          ST_CRC:    n_crc++;
          default: ;
        endcase
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0d] frame %0d mismatch", cycles, frames_checked);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("watchdog: %0d cycles, %0d of %0d bytes taken, %0d frames outstanding",
               cycles, bytes_accepted, bytes_queued, expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a clean frame of all-ones fields, motor 8000 and gear 7FFF; one
    // byte with no frame start after it (wraps to byte 0); then a frame start
    // one byte in, dropping that partial frame, zero id, motor 7FFF, gear 8000 and
    // a bad CRC so every field still shows up on a faulty frame.
    queue_frame(FR_GOOD, 8'hFF, 8'hFF, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF,
                FRAME_BYTES, 1'b1, POLY_RESET, SEED_RESET);
    queue_byte(8'h00, 1'b0);
    queue_frame(FR_BAD_CRC, 8'h00, 8'h00, 16'h7FFF, 16'h8000, 8'h02, 8'h00, 8'h00,
                FRAME_BYTES, 1'b0, POLY_RESET, SEED_RESET);

    // reset settings with no idling, then written settings incl. the extremes
    run_phase(1'b0, POLY_RESET, SEED_RESET, 0, 0, 210);
    run_phase(1'b1, 16'h1021, 16'hFFFF, 6, 4, 235);
    run_phase(1'b1, 16'h0000, 16'h0000, 2, 20, 235);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 10, 2, 235);
    run_phase(1'b1, 16'h8005, 16'($urandom), 3, 8, 235);
    run_phase(1'b1, 16'($urandom), 16'($urandom), 1, 1, 235);
    run_phase(1'b1, POLY_RESET, SEED_RESET, 4, 12, 235);

    wait_drained();
    // catch any stray result after the last frame
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes, %0d frames checked (%0d valid, %0d marker fault, %0d crc fault)",
             bytes_accepted, frames_checked, n_valid, n_marker, n_crc);
    $display("%0d partial frames dropped, %0d crc settings, %0d mismatches",
             frames_dropped, settings_run, mismatches);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/cfrp_pkg.sv
rtl/cfrp_crc8.sv
rtl/cfrp_frame.sv
rtl/cfrp_out_reg.sv
rtl/crc_framed_reply_parser.sv
test/tb_crc_framed_reply_parser.sv
